@@ src/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// No dependencies; every other file of the block uses this package.
package mexp_pkg;

    localparam int WIDTH         = 32;
    localparam int CNT_W         = $clog2(WIDTH);
    localparam int MODULUS_RESET = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_DBL,
        S_ADD,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_ACC,
        OP_SQUARE
    } t_op;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] result;
    } t_core_status;

endpackage

@@ src/mexp_ifs.sv @@
// Valid/ready channel interfaces for operands and results.
// Depends on mexp_pkg for the word width.
interface mexp_in_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::WIDTH-1:0] base_value;
    logic [mexp_pkg::WIDTH-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

@@ src/modular_exponentiation_top.sv @@
// Modular exponentiation: power_result = base_value ** exponent mod modulus, with
// right-to-left square-and-multiply over one shared modular adder. One transaction
// is in flight at a time; the input channel is ready only while the core is idle.
// After acceptance the base is first reduced against the modulus, one bit per step;
// then each set exponent bit costs a modular product into the accumulator, and each
// exponent bit up to the highest set one costs a squaring of the base. Each modular
// product runs a doubling step and an add step per multiplier bit.
// An exponent of zero returns 1; a modulus of zero returns 0 at once. The result
// sits in an output register, so the next transaction may start while it waits.
// Depends on mexp_pkg, mexp_ifs, mexp_core and mexp_addmod.
module modular_exponentiation_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mexp_in_if.sink                    i_in,
    mexp_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [mexp_pkg::WIDTH-1:0] i_cfg_wdata
);
    logic [mexp_pkg::WIDTH-1:0] r_modulus;
    logic                       r_ovalid, n_ovalid;
    logic [mexp_pkg::WIDTH-1:0] r_odata;

    mexp_pkg::t_core_status core_status;
    logic                   core_ready;
    logic                   take;

    assign take = core_status.done && (!r_ovalid || o_out.ready);

    mexp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in.valid && core_ready),
        .i_base    (i_in.base_value),
        .i_exp     (i_in.exponent),
        .i_modulus (r_modulus),
        .i_take    (take),
        .o_ready   (core_ready),
        .o_status  (core_status)
    );

    assign i_in.ready         = core_ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.power_result = r_odata;

    always_comb begin
        n_ovalid = r_ovalid;
        if (take) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::WIDTH'(mexp_pkg::MODULUS_RESET);
            r_ovalid  <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
        if (take) begin
            r_odata <= core_status.result;
        end
    end

endmodule

@@ src/mexp_addmod.sv @@
// Shared modular adder: (x + y + cin) reduced once against the modulus.
// Callers keep x + y + cin below twice the modulus. Depends on mexp_pkg.
module mexp_addmod (
    input  logic [mexp_pkg::WIDTH-1:0] i_x,
    input  logic [mexp_pkg::WIDTH-1:0] i_y,
    input  logic                       i_cin,
    input  logic [mexp_pkg::WIDTH-1:0] i_mod,
    output logic [mexp_pkg::WIDTH-1:0] o_sum
);
    logic [mexp_pkg::WIDTH:0] sum_raw;
    logic [mexp_pkg::WIDTH:0] sum_sub;

    assign sum_raw = {1'b0, i_x} + {1'b0, i_y} + {{mexp_pkg::WIDTH{1'b0}}, i_cin};
    assign sum_sub = sum_raw - {1'b0, i_mod};
    assign o_sum   = (sum_raw >= {1'b0, i_mod}) ? sum_sub[mexp_pkg::WIDTH-1:0]
                                                : sum_raw[mexp_pkg::WIDTH-1:0];
endmodule

@@ src/mexp_core.sv @@
// Sequencer for square-and-multiply around one shared modular adder.
// Depends on mexp_pkg and mexp_addmod.
module mexp_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mexp_pkg::WIDTH-1:0] i_base,
    input  logic [mexp_pkg::WIDTH-1:0] i_exp,
    input  logic [mexp_pkg::WIDTH-1:0] i_modulus,
    input  logic                       i_take,
    output logic                       o_ready,
    output mexp_pkg::t_core_status     o_status
);
    localparam int W = mexp_pkg::WIDTH;
    localparam int C = mexp_pkg::CNT_W;

    mexp_pkg::t_state r_state, n_state;
    mexp_pkg::t_op    r_op, n_op;
    logic [W-1:0]     r_mod, n_mod;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_base, n_base;
    logic [W-1:0]     r_exp, n_exp;
    logic [W-1:0]     r_prod, n_prod;
    logic [W-1:0]     r_mplier, n_mplier;
    logic [C-1:0]     r_cnt, n_cnt;

    logic [W-1:0] add_y;
    logic         add_cin;
    logic [W-1:0] add_sum;
    logic         last;

    assign last = (r_cnt == C'(W - 1));

    // Doubling and division steps add prod to itself; the add step brings in the base
    always_comb begin
        add_y   = r_prod;
        add_cin = 1'b0;
        case (r_state)
            mexp_pkg::S_REDUCE: add_cin = r_mplier[W-1];
            mexp_pkg::S_ADD:    add_y   = r_mplier[W-1] ? r_base : '0;
            default:            add_y   = r_prod;
        endcase
    end

    mexp_addmod u_addmod (
        .i_x   (r_prod),
        .i_y   (add_y),
        .i_cin (add_cin),
        .i_mod (r_mod),
        .o_sum (add_sum)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_modulus == '0) ? mexp_pkg::S_DONE : mexp_pkg::S_REDUCE;
                end
            end
            mexp_pkg::S_REDUCE: begin
                if (last) begin
                    n_state = mexp_pkg::S_CHECK;
                end
            end
            mexp_pkg::S_CHECK: begin
                n_state = (r_exp == '0) ? mexp_pkg::S_DONE : mexp_pkg::S_DBL;
            end
            mexp_pkg::S_DBL: begin
                n_state = mexp_pkg::S_ADD;
            end
            mexp_pkg::S_ADD: begin
                if (last && r_op == mexp_pkg::OP_SQUARE) begin
                    n_state = mexp_pkg::S_CHECK;
                end else begin
                    n_state = mexp_pkg::S_DBL;
                end
            end
            mexp_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = mexp_pkg::S_IDLE;
                end
            end
            default: n_state = mexp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_op     = r_op;
        n_mod    = r_mod;
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_prod   = r_prod;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_mod    = i_modulus;
                    n_exp    = i_exp;
                    n_mplier = i_base;
                    n_prod   = '0;
                    n_cnt    = '0;
                    n_acc    = (i_modulus == '0) ? '0 : W'(1);
                end
            end
            mexp_pkg::S_REDUCE: begin
                // restoring remainder: shift in one base bit per cycle
                n_prod   = add_sum;
                n_mplier = {r_mplier[W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (last) begin
                    n_base = add_sum;
                end
            end
            mexp_pkg::S_CHECK: begin
                if (r_exp != '0) begin
                    n_op     = r_exp[0] ? mexp_pkg::OP_ACC : mexp_pkg::OP_SQUARE;
                    n_mplier = r_exp[0] ? r_acc : r_base;
                    n_prod   = '0;
                    n_cnt    = '0;
                end
            end
            mexp_pkg::S_DBL: begin
                n_prod = add_sum;
            end
            mexp_pkg::S_ADD: begin
                n_prod   = add_sum;
                n_mplier = {r_mplier[W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (last) begin
                    if (r_op == mexp_pkg::OP_ACC) begin
                        // multiply done; square the base next
                        n_acc    = add_sum;
                        n_op     = mexp_pkg::OP_SQUARE;
                        n_mplier = r_base;
                        n_prod   = '0;
                        n_cnt    = '0;
                    end else begin
                        n_base = add_sum;
                        n_exp  = {1'b0, r_exp[W-1:1]};
                    end
                end
            end
            default: begin
                n_prod = r_prod;
            end
        endcase
    end

    always_comb begin
        o_ready         = (r_state == mexp_pkg::S_IDLE);
        o_status.done   = (r_state == mexp_pkg::S_DONE);
        o_status.result = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op     <= n_op;
        r_mod    <= n_mod;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_exp    <= n_exp;
        r_prod   <= n_prod;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
    end

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_REDUCE || r_state == mexp_pkg::S_DBL ||
         r_state == mexp_pkg::S_ADD) |-> (r_prod < r_mod))
        else $error("partial product not below modulus");

    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_DBL || r_state == mexp_pkg::S_ADD) |-> (r_base < r_mod))
        else $error("multiplicand not reduced");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_CHECK && r_exp == '0) |=> (r_state == mexp_pkg::S_DONE))
        else $error("exhausted exponent did not finish");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_DONE && i_take) |=> (r_state == mexp_pkg::S_IDLE))
        else $error("core held after result taken");

endmodule
